>>> rtl/core/ifd_pkg.sv
`timescale 1ns / 1ps

package ifd_pkg;

  // Reset values of the configuration registers.
  localparam logic [7:0] HEADER_RESET  = 8'hFD;
  localparam logic [7:0] CHECK_RESET   = 8'h00;
  localparam logic [7:0] TRAILER_RESET = 8'hFF;
  localparam logic [7:0] LIMIT_RESET   = 8'd10;

  // Saturation value of the consecutive-wrong counter.
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_CHECK   = 2'd1;
  localparam logic [1:0] REG_TRAILER = 2'd2;
  localparam logic [1:0] REG_LIMIT   = 2'd3;

  // Result kinds.
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Configuration handed to the parser.
  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] check_byte;
    logic [7:0] trailer_byte;
    logic [7:0] wrong_limit;
  } cfg_t;

  // One result from the parser; valid marks that the request produced one.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] pixel_value;
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;
    logic       frame_ok;
    logic       header_bad;
    logic       checksum_bad;
    logic       trailer_bad;
    logic       gave_up;
    logic [7:0] wrong_count;
    logic [7:0] frame_width;
    logic [7:0] frame_height;
  } res_t;

endpackage

>>> rtl/core/ifd_parser.sv
`timescale 1ns / 1ps

module ifd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              reply_start,
  input  ifd_pkg::cfg_t     cfg,
  output ifd_pkg::res_t     res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_WIDTH   = 3'd1;
  localparam logic [2:0] PH_HEIGHT  = 3'd2;
  localparam logic [2:0] PH_PIXELS  = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;
  localparam logic [2:0] PH_TRAILER = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  logic [2:0] phase, phase_next;
  logic [7:0] width_seen, width_seen_next;
  logic [7:0] height_seen, height_seen_next;
  logic [7:0] row_index, row_index_next;
  logic [7:0] col_index, col_index_next;
  logic [7:0] wrong_counter, wrong_counter_next;
  logic       header_flag, header_flag_next;
  logic       check_flag, check_flag_next;

  logic [7:0] count_inc;
  logic       col_last;
  logic       row_last;
  logic       emit_pixel;
  logic       emit_verdict;
  logic       verdict_ok;
  logic       verdict_tbad;
  logic       verdict_gave;

  // Saturating increment of the wrong counter and the end-of-line tests.
  assign count_inc = (wrong_counter == ifd_pkg::COUNT_MAX) ? ifd_pkg::COUNT_MAX
                                                           : wrong_counter + 8'd1;
  assign col_last = ({1'b0, col_index} + 9'd1) >= {1'b0, width_seen};
  assign row_last = ({1'b0, row_index} + 9'd1) >= {1'b0, height_seen};

  // Next state of the parse for the byte presented this cycle.
  always_comb begin
    phase_next         = phase;
    width_seen_next    = width_seen;
    height_seen_next   = height_seen;
    row_index_next     = row_index;
    col_index_next     = col_index;
    wrong_counter_next = wrong_counter;
    header_flag_next   = header_flag;
    check_flag_next    = check_flag;
    emit_pixel         = 1'b0;
    emit_verdict       = 1'b0;
    verdict_ok         = 1'b0;
    verdict_tbad       = 1'b0;
    verdict_gave       = 1'b0;
    if (reply_start) begin
      // A new reply restarts the parse, whatever was in progress.
      width_seen_next  = 8'd0;
      height_seen_next = 8'd0;
      row_index_next   = 8'd0;
      col_index_next   = 8'd0;
      header_flag_next = 1'b0;
      check_flag_next  = 1'b0;
      phase_next       = PH_WIDTH;
      if (data_byte != cfg.header_byte) begin
        header_flag_next   = 1'b1;
        wrong_counter_next = count_inc;
        if (count_inc > cfg.wrong_limit) begin
          phase_next   = PH_DONE;
          emit_verdict = 1'b1;
          verdict_gave = 1'b1;
        end
      end
    end else begin
      unique case (phase)
        PH_WIDTH: begin
          width_seen_next = data_byte;
          phase_next      = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          height_seen_next = data_byte;
          row_index_next   = 8'd0;
          col_index_next   = 8'd0;
          if (width_seen == 8'd0 || data_byte == 8'd0) begin
            phase_next = PH_CHECK;
          end else begin
            phase_next = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          emit_pixel = 1'b1;
          if (col_last) begin
            col_index_next = 8'd0;
            if (row_last) begin
              phase_next = PH_CHECK;
            end else begin
              row_index_next = row_index + 8'd1;
            end
          end else begin
            col_index_next = col_index + 8'd1;
          end
        end
        PH_CHECK: begin
          phase_next = PH_TRAILER;
          if (data_byte != cfg.check_byte) begin
            check_flag_next    = 1'b1;
            wrong_counter_next = count_inc;
            if (count_inc > cfg.wrong_limit) begin
              phase_next   = PH_DONE;
              emit_verdict = 1'b1;
              verdict_gave = 1'b1;
            end
          end
        end
        PH_TRAILER: begin
          phase_next   = PH_DONE;
          emit_verdict = 1'b1;
          if (data_byte == cfg.trailer_byte) begin
            wrong_counter_next = 8'd0;
            verdict_ok         = 1'b1;
          end else begin
            wrong_counter_next = count_inc;
            verdict_tbad       = 1'b1;
          end
        end
        default: begin
          // Idle or finished: stray bytes are dropped.
        end
      endcase
    end
  end

  // Result for this request: a pixel takes the current coordinates, a verdict is built from the updated state.
  always_comb begin
    res              = '0;
    res.valid        = take & (emit_pixel | emit_verdict);
    if (emit_pixel) begin
      res.kind        = ifd_pkg::KIND_PIXEL;
      res.pixel_value = data_byte;
      res.pixel_row   = row_index;
      res.pixel_col   = col_index;
    end else begin
      res.kind         = ifd_pkg::KIND_VERDICT;
      res.frame_ok     = verdict_ok;
      res.header_bad   = header_flag_next;
      res.checksum_bad = check_flag_next;
      res.trailer_bad  = verdict_tbad;
      res.gave_up      = verdict_gave;
      res.wrong_count  = wrong_counter_next;
      res.frame_width  = width_seen_next;
      res.frame_height = height_seen_next;
    end
  end

  // Parse state, updated only when a request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      width_seen    <= 8'd0;
      height_seen   <= 8'd0;
      row_index     <= 8'd0;
      col_index     <= 8'd0;
      wrong_counter <= 8'd0;
      header_flag   <= 1'b0;
      check_flag    <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      width_seen    <= width_seen_next;
      height_seen   <= height_seen_next;
      row_index     <= row_index_next;
      col_index     <= col_index_next;
      wrong_counter <= wrong_counter_next;
      header_flag   <= header_flag_next;
      check_flag    <= check_flag_next;
    end
  end

  // The pixel phase is only entered with a non-empty frame.
  a_pixels_nonempty: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PIXELS |-> width_seen != 8'd0 && height_seen != 8'd0)
    else $error("pixel phase with an empty frame");

  // Pixel coordinates stay inside the frame.
  a_pixel_in_frame: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PIXELS |-> col_index < width_seen && row_index < height_seen)
    else $error("pixel coordinates outside the frame");

  // An accepted frame leaves the wrong counter cleared.
  a_ok_clears: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == ifd_pkg::KIND_VERDICT && res.frame_ok
    |=> wrong_counter == 8'd0)
    else $error("wrong counter not cleared after accepted frame");

  // A pixel result comes only from the pixel phase.
  a_pixel_phase: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == ifd_pkg::KIND_PIXEL |-> phase == PH_PIXELS)
    else $error("pixel result outside the pixel phase");

endmodule

>>> rtl/core/image_frame_deframer.sv
`timescale 1ns / 1ps
// A result is shown on the output register in the cycle after its request is accepted.
// One byte per cycle if not stalled; the single output register refills in the cycle it drains.
// Input stall is raised only while a result is held in the output register under output stall.
// Reset (synchronous, rst high): parse idle, counters and flags zero, output empty,
// registers header 0xFD, check 0x00, trailer 0xFF, limit 10.

module image_frame_deframer (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ifd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              reply_start,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              kind,
  output logic [7:0]                        pixel_value,
  output logic [7:0]                        pixel_row,
  output logic [7:0]                        pixel_col,
  output logic                              frame_ok,
  output logic                              header_bad,
  output logic                              checksum_bad,
  output logic                              trailer_bad,
  output logic                              gave_up,
  output logic [7:0]                        wrong_count,
  output logic [7:0]                        frame_width,
  output logic [7:0]                        frame_height
);

  ifd_pkg::cfg_t cfg;
  ifd_pkg::res_t res;
  ifd_pkg::res_t out_reg;
  logic          cfg_write;
  logic [1:0]    cfg_sel;
  logic          take;
  logic          out_load;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_sel   = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte  <= ifd_pkg::HEADER_RESET;
      cfg.check_byte   <= ifd_pkg::CHECK_RESET;
      cfg.trailer_byte <= ifd_pkg::TRAILER_RESET;
      cfg.wrong_limit  <= ifd_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        ifd_pkg::REG_HEADER:  cfg.header_byte  <= pwdata[7:0];
        ifd_pkg::REG_CHECK:   cfg.check_byte   <= pwdata[7:0];
        ifd_pkg::REG_TRAILER: cfg.trailer_byte <= pwdata[7:0];
        ifd_pkg::REG_LIMIT:   cfg.wrong_limit  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_sel)
      ifd_pkg::REG_HEADER:  prdata = {24'd0, cfg.header_byte};
      ifd_pkg::REG_CHECK:   prdata = {24'd0, cfg.check_byte};
      ifd_pkg::REG_TRAILER: prdata = {24'd0, cfg.trailer_byte};
      ifd_pkg::REG_LIMIT:   prdata = {24'd0, cfg.wrong_limit};
      default:              prdata = 32'd0;
    endcase
  end

  // Handshake: the output register may be refilled when empty or being drained.
  assign out_load = ~out_valid | ~out_stall;
  assign in_stall = ~out_load;
  assign take     = in_valid & out_load;

  ifd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (data_byte),
    .reply_start (reply_start),
    .cfg         (cfg),
    .res         (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && res.valid) begin
      out_reg <= res;
    end
  end

  assign kind         = out_reg.kind;
  assign pixel_value  = out_reg.pixel_value;
  assign pixel_row    = out_reg.pixel_row;
  assign pixel_col    = out_reg.pixel_col;
  assign frame_ok     = out_reg.frame_ok;
  assign header_bad   = out_reg.header_bad;
  assign checksum_bad = out_reg.checksum_bad;
  assign trailer_bad  = out_reg.trailer_bad;
  assign gave_up      = out_reg.gave_up;
  assign wrong_count  = out_reg.wrong_count;
  assign frame_width  = out_reg.frame_width;
  assign frame_height = out_reg.frame_height;

endmodule
